// ===== hw/rtl/ptvc_pkg.sv =====
// Package: shared types, register indexes, state codes and helper functions.
package ptvc_pkg;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_GOAL_X      = 3'd1;
  localparam logic [2:0] REG_GOAL_Y      = 3'd2;
  localparam logic [2:0] REG_GOAL_HEAD   = 3'd3;
  localparam logic [2:0] REG_MAX_LIN     = 3'd4;
  localparam logic [2:0] REG_MAX_TURN    = 3'd5;
  localparam logic [2:0] REG_MARGIN_XY   = 3'd6;
  localparam logic [2:0] REG_MARGIN_HEAD = 3'd7;

  // tracking modes
  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_POSITION = 3'd1;
  localparam logic [2:0] MODE_X        = 3'd2;
  localparam logic [2:0] MODE_Y        = 3'd3;
  localparam logic [2:0] MODE_POSE     = 3'd4;
  localparam logic [2:0] MODE_ORIENT   = 3'd5;
  localparam logic [2:0] MODE_X_THETA  = 3'd6;
  localparam logic [2:0] MODE_Y_THETA  = 3'd7;

  // heading wrap limits, 0.1 degree units
  localparam logic signed [13:0] HALF_TURN = 14'sd1800;
  localparam logic signed [13:0] FULL_TURN = 14'sd3600;

  // sequencer states
  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_MX   = 13'b0000000000010,
    S_MY   = 13'b0000000000100,
    S_MH   = 13'b0000000001000,
    S_SQX  = 13'b0000000010000,
    S_SQY  = 13'b0000000100000,
    S_MM   = 13'b0000001000000,
    S_CHK  = 13'b0000010000000,
    S_SQRT = 13'b0000100000000,
    S_MULX = 13'b0001000000000,
    S_DIVX = 13'b0010000000000,
    S_MULY = 13'b0100000000000,
    S_DIVY = 13'b1000000000000
  } state_t;

  // one wrap step of the heading error toward +-1800
  function automatic logic signed [13:0] wrap_step(input logic signed [13:0] e);
    logic signed [13:0] r;
    r = e;
    if (e < -HALF_TURN) r = e + FULL_TURN;
    else if (e > HALF_TURN) r = e - FULL_TURN;
    return r;
  endfunction

  // saturate a magnitude to lim and apply the sign
  function automatic logic signed [15:0] sat_cmd(input logic neg, input logic [24:0] mag,
                                                 input logic [14:0] lim);
    logic [15:0] m;
    m = (mag > {10'd0, lim}) ? {1'b0, lim} : {1'b0, mag[14:0]};
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // move track at most step toward tgt
  function automatic logic signed [15:0] slew(input logic signed [15:0] track,
                                              input logic signed [15:0] tgt,
                                              input logic [14:0] step);
    logic signed [17:0] hi, lo, t;
    hi = 18'(track) + $signed({3'd0, step});
    lo = 18'(track) - $signed({3'd0, step});
    t  = 18'(tgt);
    if (t > hi) return hi[15:0];
    else if (t < lo) return lo[15:0];
    return tgt;
  endfunction

endpackage

// ===== hw/rtl/ptvc_if.sv =====
// Interfaces: pose input channel and velocity command result channel.
interface ptvc_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  pose_x;
  logic signed [15:0]  pose_y;
  logic signed [12:0]  pose_heading;
  modport source (output valid, pose_x, pose_y, pose_heading, input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface ptvc_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  vel_x;
  logic signed [15:0]  vel_y;
  logic signed [15:0]  turn_rate;
  logic                x_reached;
  logic                y_reached;
  logic                heading_reached;
  logic                goal_reached;
  logic                goal_just_reached;
  modport source (output valid, vel_x, vel_y, turn_rate, x_reached, y_reached,
                  heading_reached, goal_reached, goal_just_reached, input ready);
  modport sink   (input valid, vel_x, vel_y, turn_rate, x_reached, y_reached,
                  heading_reached, goal_reached, goal_just_reached, output ready);
endinterface

// ===== hw/rtl/pose_tracking_velocity_controller_core.sv =====
// Top level: pose tracking velocity controller with one shared multiplier and sqrt/divide steps.
// Flow: errors, gain products, squared lengths and a limit check; when the xy vector
// must be scaled, 26 sqrt steps follow, plus two 15-step restoring divisions on one unit.
// One pose is in work at a time; a new beat is taken while the last result still waits.
// Reset (rst_n low, synchronous): config registers, trackers and reached latch go to 0.
module pose_tracking_velocity_controller_core #(
  parameter int GAIN_XY_Q8      = 256,
  parameter int GAIN_HEADING_Q8 = 256,
  parameter int STEP_LIMIT_XY   = 50,
  parameter int STEP_LIMIT_TURN = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  ptvc_in_if.sink     in_ch,
  ptvc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptvc_pkg::*;

  localparam logic [15:0] GXY  = 16'(GAIN_XY_Q8);
  localparam logic [15:0] GH   = 16'(GAIN_HEADING_Q8);
  localparam logic [14:0] STXY = 15'(STEP_LIMIT_XY);
  localparam logic [14:0] STT  = 15'(STEP_LIMIT_TURN);

  // configuration registers
  logic [2:0]         mode_r;
  logic signed [15:0] goal_x_r, goal_y_r;
  logic signed [12:0] goal_h_r;
  logic [14:0]        max_lin_r, max_turn_r, margin_xy_r;
  logic [11:0]        margin_h_r;

  // sequencer and datapath
  state_t             state_r, state_nxt;
  logic signed [16:0] ex_r, ey_r;
  logic signed [13:0] eh_r;
  logic [24:0]        ax_r, ay_r, ah_r;
  logic [51:0]        sum_r, res_r, bit_r;
  logic [29:0]        mm_r;
  logic [40:0]        dsh_r;
  logic [14:0]        q_r, qx_r;
  logic [4:0]         cnt_r;
  logic               scale_r;
  logic               fin_r;

  // trackers and result register
  logic signed [15:0] trk_x_r, trk_y_r, trk_h_r;
  logic               latch_r;
  logic               out_valid_r;
  logic signed [15:0] o_vx_r, o_vy_r, o_vh_r;
  logic               o_rx_r, o_ry_r, o_rh_r, o_now_r, o_rise_r;

  logic               cfg_wr, in_acc, out_free;
  logic [16:0]        abs_ex, abs_ey;
  logic [13:0]        abs_eh;
  logic [25:0]        mul_a, mul_b;
  logic [51:0]        prod;
  logic [51:0]        sq_t;
  logic signed [13:0] eh_in;
  logic               use_x, use_y, use_h, pos;
  logic               rx, ry, rh, now;
  logic signed [15:0] nx, ny, nh;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !fin_r;
  assign out_free = !out_valid_r || out_ch.ready;

  // register read back
  always_comb begin
    unique case (paddr[4:2])
      REG_MODE:        prdata = {29'd0, mode_r};
      REG_GOAL_X:      prdata = 32'(goal_x_r);
      REG_GOAL_Y:      prdata = 32'(goal_y_r);
      REG_GOAL_HEAD:   prdata = 32'(goal_h_r);
      REG_MAX_LIN:     prdata = {17'd0, max_lin_r};
      REG_MAX_TURN:    prdata = {17'd0, max_turn_r};
      REG_MARGIN_XY:   prdata = {17'd0, margin_xy_r};
      REG_MARGIN_HEAD: prdata = {20'd0, margin_h_r};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NONE;
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      goal_h_r    <= '0;
      max_lin_r   <= '0;
      max_turn_r  <= '0;
      margin_xy_r <= '0;
      margin_h_r  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MODE:        mode_r      <= pwdata[2:0];
        REG_GOAL_X:      goal_x_r    <= pwdata[15:0];
        REG_GOAL_Y:      goal_y_r    <= pwdata[15:0];
        REG_GOAL_HEAD:   goal_h_r    <= pwdata[12:0];
        REG_MAX_LIN:     max_lin_r   <= pwdata[14:0];
        REG_MAX_TURN:    max_turn_r  <= pwdata[14:0];
        REG_MARGIN_XY:   margin_xy_r <= pwdata[14:0];
        REG_MARGIN_HEAD: margin_h_r  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // input errors, heading wrapped into +-1800 (two steps suffice)
  assign eh_in = wrap_step(wrap_step(14'(goal_h_r) - 14'(in_ch.pose_heading)));

  assign abs_ex = ex_r[16] ? 17'(-ex_r) : 17'(ex_r);
  assign abs_ey = ey_r[16] ? 17'(-ey_r) : 17'(ey_r);
  assign abs_eh = eh_r[13] ? 14'(-eh_r) : 14'(eh_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MX:   begin mul_a = 26'(abs_ex); mul_b = 26'(GXY); end
      S_MY:   begin mul_a = 26'(abs_ey); mul_b = 26'(GXY); end
      S_MH:   begin mul_a = 26'(abs_eh); mul_b = 26'(GH); end
      S_SQX:  begin mul_a = 26'(ax_r); mul_b = 26'(ax_r); end
      S_SQY:  begin mul_a = 26'(ay_r); mul_b = 26'(ay_r); end
      S_MM:   begin mul_a = 26'(max_lin_r); mul_b = 26'(max_lin_r); end
      S_MULX: begin mul_a = 26'(ax_r); mul_b = 26'(max_lin_r); end
      S_MULY: begin mul_a = 26'(ay_r); mul_b = 26'(max_lin_r); end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;
  assign sq_t = res_r + bit_r;

  // mode decode and reached flags
  assign use_x = (mode_r == MODE_POSITION) || (mode_r == MODE_X) ||
                 (mode_r == MODE_POSE) || (mode_r == MODE_X_THETA);
  assign use_y = (mode_r == MODE_POSITION) || (mode_r == MODE_Y) ||
                 (mode_r == MODE_POSE) || (mode_r == MODE_Y_THETA);
  assign use_h = mode_r[2];
  assign pos   = (mode_r == MODE_POSITION) || (mode_r == MODE_POSE);
  assign rx    = use_x && (abs_ex < {2'd0, margin_xy_r});
  assign ry    = use_y && (abs_ey < {2'd0, margin_xy_r});
  assign rh    = use_h && (abs_eh < {2'd0, margin_h_r});
  assign now   = (mode_r != MODE_NONE) && (!use_x || rx) && (!use_y || ry) && (!use_h || rh);

  // new commands; scaled vector only when both axes remain and exceed the limit
  always_comb begin
    if (max_lin_r == '0 || rx) nx = '0;
    else if (scale_r) nx = sat_cmd(ex_r[16], {10'd0, qx_r}, max_lin_r);
    else nx = sat_cmd(ex_r[16], ax_r, max_lin_r);
    if (max_lin_r == '0 || ry) ny = '0;
    else if (scale_r) ny = sat_cmd(ey_r[16], {10'd0, q_r}, max_lin_r);
    else ny = sat_cmd(ey_r[16], ay_r, max_lin_r);
    if (max_turn_r == '0 || rh) nh = '0;
    else nh = sat_cmd(eh_r[13], ah_r, max_turn_r);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_MX;
      S_MX:   state_nxt = S_MY;
      S_MY:   state_nxt = S_MH;
      S_MH:   state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_MM;
      S_MM:   state_nxt = S_CHK;
      S_CHK:  state_nxt = (pos && !rx && !ry && max_lin_r != '0 && sum_r > 52'(mm_r))
                          ? S_SQRT : S_IDLE;
      S_SQRT: if (cnt_r == '0) state_nxt = S_MULX;
      S_MULX: state_nxt = S_DIVX;
      S_DIVX: if (cnt_r == '0) state_nxt = S_MULY;
      S_MULY: state_nxt = S_DIVY;
      S_DIVY: if (cnt_r == '0) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_CHK && state_nxt == S_IDLE) ||
          (state_r == S_DIVY && cnt_r == '0))
        fin_r <= 1'b1;
      else if (fin_r && out_free)
        fin_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        ex_r    <= 17'(goal_x_r) - 17'(in_ch.pose_x);
        ey_r    <= 17'(goal_y_r) - 17'(in_ch.pose_y);
        eh_r    <= eh_in;
        scale_r <= 1'b0;
      end
      S_MX:  ax_r  <= prod[32:8];
      S_MY:  ay_r  <= prod[32:8];
      S_MH:  ah_r  <= prod[32:8];
      S_SQX: sum_r <= prod;
      S_SQY: sum_r <= sum_r + prod;
      S_MM:  mm_r  <= prod[29:0];
      S_CHK: begin
        scale_r <= (state_nxt == S_SQRT);
        res_r   <= '0;
        bit_r   <= 52'd1 << 50;
        cnt_r   <= 5'd25;
      end
      S_SQRT: begin
        if (sum_r >= sq_t) begin
          sum_r <= sum_r - sq_t;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 5'd1;
      end
      S_MULX, S_MULY: begin
        sum_r <= prod;
        dsh_r <= 41'(res_r[25:0]) << 14;
        q_r   <= '0;
        cnt_r <= 5'd14;
      end
      S_DIVX, S_DIVY: begin
        if (sum_r[40:0] >= dsh_r) begin
          sum_r <= sum_r - 52'(dsh_r);
          q_r   <= {q_r[13:0], 1'b1};
        end else begin
          q_r   <= {q_r[13:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 5'd1;
        if (state_r == S_DIVY) qx_r <= qx_r;
      end
      default: ;
    endcase
    if (state_r == S_MULY) qx_r <= q_r;
  end

  // trackers, latch and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_x_r     <= '0;
      trk_y_r     <= '0;
      trk_h_r     <= '0;
      latch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (fin_r && out_free) begin
      trk_x_r     <= use_x ? slew(trk_x_r, nx, STXY) : '0;
      trk_y_r     <= use_y ? slew(trk_y_r, ny, STXY) : '0;
      trk_h_r     <= use_h ? slew(trk_h_r, nh, STT) : '0;
      o_vx_r      <= use_x ? slew(trk_x_r, nx, STXY) : '0;
      o_vy_r      <= use_y ? slew(trk_y_r, ny, STXY) : '0;
      o_vh_r      <= use_h ? slew(trk_h_r, nh, STT) : '0;
      o_rx_r      <= rx;
      o_ry_r      <= ry;
      o_rh_r      <= rh;
      o_now_r     <= now;
      o_rise_r    <= now && !latch_r;
      latch_r     <= now;
      out_valid_r <= 1'b1;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_wr && (paddr[4:2] == REG_GOAL_X || paddr[4:2] == REG_GOAL_Y ||
                     paddr[4:2] == REG_GOAL_HEAD))
        latch_r <= 1'b0;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.vel_x             = o_vx_r;
  assign out_ch.vel_y             = o_vy_r;
  assign out_ch.turn_rate         = o_vh_r;
  assign out_ch.x_reached         = o_rx_r;
  assign out_ch.y_reached         = o_ry_r;
  assign out_ch.heading_reached   = o_rh_r;
  assign out_ch.goal_reached      = o_now_r;
  assign out_ch.goal_just_reached = o_rise_r;

  // checks
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input taken while a pose is in work");
  a_rise_implies_goal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_rise_r |-> o_now_r)
    else $error("goal edge without goal reached");
  a_none_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && mode_r == MODE_NONE |->
      o_vx_r == '0 && o_vy_r == '0 && o_vh_r == '0 && !o_now_r)
    else $error("mode none gave a nonzero result");
  a_scale_only_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT |-> pos && !rx && !ry)
    else $error("vector scaling outside position modes");

endmodule
